// ===== hw/rtl/tbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsd_pkg
// Shared types, constants and helpers for the text/binary stream deframer.
// ----------------------------------------------------------------------------
package tbsd_pkg;

  localparam int LENGTH_FIELD_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF        = 4;
  localparam int PAY_W                  = 32;
  localparam int BYTE_W                 = 8;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_BIN  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TEXT = 3'b010,
    MODE_BIN  = 3'b100
  } mode_t;

  // One command per input item that yields results: release `rel` held
  // terminator bytes, then optionally one tail result.
  typedef struct packed {
    logic              kind;
    logic [1:0]        rel;
    logic              tail;
    logic [BYTE_W-1:0] tail_byte;
    logic              tail_has;
    logic              tail_last;
  } cmd_t;

  // CR LF CR LF
  function automatic logic [BYTE_W-1:0] term_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    b = idx[0] ? CH_LF : CH_CR;
    return b;
  endfunction

endpackage

// ===== hw/rtl/text_binary_stream_deframer_top.sv =====
// ----------------------------------------------------------------------------
// text_binary_stream_deframer_top
// Splits a byte stream into length-prefixed binary packets and CR LF CR LF
// terminated text packets.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata[7:0] in_byte
//  out_    | out | out_tvalid/tready   | tdata byte+has, tuser kind, tlast last
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_data start byte of a binary packet
//
//  Takes one byte per cycle while the command queue has room.
//  Results leave one per cycle while out_tready is high; a text byte that
//  breaks a partial terminator match yields up to 4 results, which the queue
//  and output register absorb; each command goes through both in that order.
//  Reset is synchronous on rst_n; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_binary_stream_deframer_top #(
  parameter int LENGTH_FIELD_BYTES = tbsd_pkg::LENGTH_FIELD_BYTES_DEF,
  parameter int QUEUE_DEPTH        = tbsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [8] has_byte, [15:9] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  logic           full, push, pop, head_valid, in_acc;
  tbsd_pkg::cmd_t cmd, head_cmd;
  logic [7:0]     data_byte;
  logic           has_byte;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_acc    = in_tvalid && !full;

  tbsd_front #(.LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_accept (in_acc),
    .in_byte   (in_tdata),
    .push      (push),
    .cmd       (cmd)
  );

  tbsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  tbsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (data_byte),
    .out_has    (has_byte),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'b0, has_byte, data_byte};

endmodule

// ===== hw/rtl/tbsd_front.sv =====
// ----------------------------------------------------------------------------
// tbsd_front
// Accepts bytes, tracks packet mode, length header and terminator match, and
// issues one command per byte that yields results.
// ----------------------------------------------------------------------------
module tbsd_front #(
  parameter int LENGTH_FIELD_BYTES = tbsd_pkg::LENGTH_FIELD_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [tbsd_pkg::BYTE_W-1:0] cfg_data,
  input  logic                       in_accept,
  input  logic [tbsd_pkg::BYTE_W-1:0] in_byte,
  output logic                       push,
  output tbsd_pkg::cmd_t             cmd
);

  localparam int HW = $clog2(LENGTH_FIELD_BYTES + 1);

  tbsd_pkg::mode_t              mode_r, mode_nxt;
  logic [HW-1:0]                hdr_r, hdr_nxt;
  logic [tbsd_pkg::PAY_W-1:0]   pay_r, pay_nxt;
  logic [1:0]                   m_r, m_nxt;
  logic [tbsd_pkg::BYTE_W-1:0]  prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= tbsd_pkg::MODE_IDLE;
      hdr_r    <= '0;
      pay_r    <= '0;
      m_r      <= '0;
      prefix_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      hdr_r  <= hdr_nxt;
      pay_r  <= pay_nxt;
      m_r    <= m_nxt;
      if (cfg_valid) begin
        prefix_r <= cfg_data;
      end
    end
  end

  always_comb begin
    logic                       text_go;
    logic [1:0]                 m_cur;
    logic [tbsd_pkg::PAY_W-1:0] pay_sh;
    logic [tbsd_pkg::PAY_W-1:0] pay_dec;
    mode_nxt = mode_r;
    hdr_nxt  = hdr_r;
    pay_nxt  = pay_r;
    m_nxt    = m_r;
    cmd      = '0;
    text_go  = 1'b0;
    m_cur    = m_r;
    pay_sh   = {pay_r[tbsd_pkg::PAY_W-tbsd_pkg::BYTE_W-1:0], in_byte};
    pay_dec  = pay_r - 1'b1;
    if (in_accept) begin
      unique case (mode_r)
        tbsd_pkg::MODE_BIN: begin
          cmd.kind = tbsd_pkg::KIND_BIN;
          if (hdr_r != '0) begin
            hdr_nxt = hdr_r - 1'b1;
            pay_nxt = pay_sh;
            if (hdr_r == HW'(1) && pay_sh == '0) begin
              cmd.tail      = 1'b1;
              cmd.tail_last = 1'b1;
              mode_nxt      = tbsd_pkg::MODE_IDLE;
            end
          end else begin
            pay_nxt       = pay_dec;
            cmd.tail      = 1'b1;
            cmd.tail_byte = in_byte;
            cmd.tail_has  = 1'b1;
            cmd.tail_last = (pay_dec == '0);
            if (pay_dec == '0) begin
              mode_nxt = tbsd_pkg::MODE_IDLE;
            end
          end
        end
        tbsd_pkg::MODE_TEXT: begin
          text_go = 1'b1;
        end
        default: begin
          if (in_byte == prefix_r) begin
            mode_nxt = tbsd_pkg::MODE_BIN;
            hdr_nxt  = HW'(LENGTH_FIELD_BYTES);
            pay_nxt  = '0;
          end else begin
            mode_nxt = tbsd_pkg::MODE_TEXT;
            text_go  = 1'b1;
            m_cur    = '0;
          end
        end
      endcase

      if (text_go) begin
        cmd.kind = tbsd_pkg::KIND_TEXT;
        if (in_byte == tbsd_pkg::term_byte(m_cur)) begin
          if (m_cur == 2'd3) begin
            cmd.tail      = 1'b1;
            cmd.tail_last = 1'b1;
            mode_nxt      = tbsd_pkg::MODE_IDLE;
            m_nxt         = '0;
          end else begin
            m_nxt = m_cur + 1'b1;
          end
        end else if (in_byte == tbsd_pkg::CH_CR) begin
          cmd.rel = m_cur;
          m_nxt   = 2'd1;
        end else begin
          cmd.rel       = m_cur;
          cmd.tail      = 1'b1;
          cmd.tail_byte = in_byte;
          cmd.tail_has  = 1'b1;
          m_nxt         = '0;
        end
      end
    end
    push = cmd.tail || (cmd.rel != '0);
  end

endmodule

// ===== hw/rtl/tbsd_queue.sv =====
// ----------------------------------------------------------------------------
// tbsd_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module tbsd_queue #(
  parameter int DEPTH = tbsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tbsd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tbsd_pkg::cmd_t head_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tbsd_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full       = (cnt_r == (AW+1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && head_valid) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && head_valid);
    end
  end

endmodule

// ===== hw/rtl/tbsd_back.sv =====
// ----------------------------------------------------------------------------
// tbsd_back
// Expands queued commands into result items, one per cycle while the output
// is not stalled, into an output register.
// ----------------------------------------------------------------------------
module tbsd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  tbsd_pkg::cmd_t              head_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [tbsd_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_has,
  output logic                        out_last
);

  logic [1:0]                  idx_r;
  logic                        vld_r;
  logic                        kind_r, has_r, last_r;
  logic [tbsd_pkg::BYTE_W-1:0] byte_r;
  logic                        load, in_rel, done;

  assign load   = head_valid && (!vld_r || out_ready);
  assign in_rel = (idx_r < head_cmd.rel);
  assign done   = head_cmd.tail ? (idx_r == head_cmd.rel)
                                : (idx_r == head_cmd.rel - 1'b1);
  assign pop    = load && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        vld_r <= 1'b1;
        idx_r <= done ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= head_cmd.kind;
      if (in_rel) begin
        byte_r <= tbsd_pkg::term_byte(idx_r);
        has_r  <= 1'b1;
        last_r <= 1'b0;
      end else begin
        byte_r <= head_cmd.tail_byte;
        has_r  <= head_cmd.tail_has;
        last_r <= head_cmd.tail_last;
      end
    end
  end

  assign out_valid = vld_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_has   = has_r;
  assign out_last  = last_r;

endmodule

// ===== hw/rtl/tbsd_checker.sv =====
// ----------------------------------------------------------------------------
// tbsd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
module tbsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("out item changed while stalled");

  // empty result is always an end marker with zero data
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("empty result not a clean end marker");

  // text packets end only with an empty marker
  a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && (out_tuser == 1'b0) |-> !out_tdata[8])
    else $error("text packet ended on a data byte");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:9] == 7'h00))
    else $error("tdata padding not zero");

endmodule

bind text_binary_stream_deframer_top tbsd_checker u_tbsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/text_binary_stream_deframer_top_test.sv =====
// ----------------------------------------------------------------------------
// text_binary_stream_deframer_top_test
// Self-checking bench for the stream deframer. Feeds directed and random byte
// streams built from binary (prefix + length + payload) and CR LF CR LF text
// packets, predicts every output item and compares field by field, with
// bursty input, random output stalls and several binary prefix settings.
// ----------------------------------------------------------------------------
module text_binary_stream_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR_BYTES = tbsd_pkg::LENGTH_FIELD_BYTES_DEF;
  localparam logic [3:0][7:0] TERM_SEQ = {tbsd_pkg::CH_LF, tbsd_pkg::CH_CR,
                                          tbsd_pkg::CH_LF, tbsd_pkg::CH_CR};

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } frame_item_t;

  class packet_scoreboard;
    tbsd_pkg::mode_t mode;
    logic [7:0]      prefix;
    int              hdr_left;
    logic [31:0]     pay_left;
    int              held;
    int              errors;
    frame_item_t     awaited_q[$];

    function new();
      mode = tbsd_pkg::MODE_IDLE;
      prefix = 8'h00;
      hdr_left = 0;
      pay_left = '0;
      held = 0;
      errors = 0;
    endfunction

    function void set_prefix(logic [7:0] v);
      prefix = v;
    endfunction

    function bit is_idle();
      return mode != tbsd_pkg::MODE_TEXT && mode != tbsd_pkg::MODE_BIN;
    endfunction

    function logic [7:0] next_term_byte();
      return TERM_SEQ[held];
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    function void push(logic kind, logic [7:0] b, logic has, logic last);
      frame_item_t r;
      r.kind = kind;
      r.data_byte = has ? b : 8'h00;
      r.has_byte = has;
      r.last = last;
      awaited_q.insert(awaited_q.size(), r);
    endfunction

    function void binary_byte(logic [7:0] b);
      if (hdr_left != 0) begin
        hdr_left--;
        if (hdr_left < 4) pay_left |= 32'(b) << (8 * hdr_left);
        if (hdr_left == 0 && pay_left == 0) begin
          push(tbsd_pkg::KIND_BIN, 8'h00, 1'b0, 1'b1);
          mode = tbsd_pkg::MODE_IDLE;
        end
        return;
      end
      pay_left--;
      push(tbsd_pkg::KIND_BIN, b, 1'b1, pay_left == 0);
      if (pay_left == 0) mode = tbsd_pkg::MODE_IDLE;
    endfunction

    function void text_byte(logic [7:0] b);
      if (b == TERM_SEQ[held]) begin
        if (held == 3) begin
          push(tbsd_pkg::KIND_TEXT, 8'h00, 1'b0, 1'b1);
          held = 0;
          mode = tbsd_pkg::MODE_IDLE;
        end else begin
          held++;
        end
        return;
      end
      for (int i = 0; i < held; i++) push(tbsd_pkg::KIND_TEXT, TERM_SEQ[i], 1'b1, 1'b0);
      if (b == tbsd_pkg::CH_CR) begin
        held = 1;
      end else begin
        push(tbsd_pkg::KIND_TEXT, b, 1'b1, 1'b0);
        held = 0;
      end
    endfunction

    // predicts the output items caused by one accepted input byte
    function void note_byte(logic [7:0] b);
      if (is_idle()) begin
        if (b == prefix) begin
          mode = tbsd_pkg::MODE_BIN;
          hdr_left = HDR_BYTES;
          pay_left = '0;
          return;
        end
        mode = tbsd_pkg::MODE_TEXT;
        held = 0;
      end
      if (mode == tbsd_pkg::MODE_BIN) binary_byte(b);
      else text_byte(b);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [15:0] tdata, logic tuser, logic tlast);
      frame_item_t want;
      if (awaited_q.size() == 0) begin
        report($sformatf("unexpected item tdata=%h tuser=%b tlast=%b",
                         tdata, tuser, tlast));
        return;
      end
      want = awaited_q.pop_front();
      if (tuser !== want.kind)
        report($sformatf("kind got %b want %b", tuser, want.kind));
      if (tdata[7:0] !== want.data_byte)
        report($sformatf("data_byte got %h want %h", tdata[7:0], want.data_byte));
      if (tdata[8] !== want.has_byte)
        report($sformatf("has_byte got %b want %b", tdata[8], want.has_byte));
      if (tlast !== want.last)
        report($sformatf("last got %b want %b", tlast, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [7:0] data_byte, [8] has_byte, [15:9] zero
  logic        out_tuser;   // [0] kind
  logic        out_tlast;

  packet_scoreboard sb = new();

  int rx_style      = 0;
  bit long_hold_req = 1'b0;
  int burst_left    = 0;
  int items_sent    = 0;

  text_binary_stream_deframer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // output side: check accepted items, stall on the selected pattern
  initial begin : result_sink
    int rx_cycle;
    int hold_left;
    rx_cycle = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready)
        sb.check_result(out_tdata, out_tuser, out_tlast);
      rx_cycle++;
      if (long_hold_req) begin
        hold_left = 80;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_style)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ((rx_cycle % 7) < 5);
          default: out_tready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  task send_item(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b);
    burst_left--;
    items_sent++;
  endtask

  task wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_prefix(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_prefix(v);
  endtask

  // keeps random bytes from opening a binary packet with a random length
  function automatic logic [7:0] avoid_prefix(logic [7:0] b);
    if (sb.is_idle() && b == sb.prefix) return b ^ 8'h01;
    return b;
  endfunction

  function automatic logic [7:0] text_content_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return tbsd_pkg::CH_CR;
    if (r < 7) return tbsd_pkg::CH_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  task close_text();
    while (!sb.is_idle()) send_item(sb.next_term_byte());
  endtask

  task send_binary_packet(input int len);
    logic [31:0] len_bits;
    len_bits = len;
    close_text();
    send_item(sb.prefix);
    for (int i = HDR_BYTES - 1; i >= 0; i--)
      send_item((i < 4) ? len_bits[8*i +: 8] : 8'h00);
    repeat (len) send_item(8'($urandom_range(0, 255)));
  endtask

  task send_text_packet();
    int n;
    n = $urandom_range(0, 12);
    send_item(avoid_prefix(8'($urandom_range(0, 255))));
    repeat (n) send_item(avoid_prefix(text_content_byte()));
    close_text();
  endtask

  task run_random(input int count);
    int target;
    int pick;
    int r;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        r = $urandom_range(0, 9);
        if (r < 2) send_binary_packet(0);
        else if (r == 9) send_binary_packet($urandom_range(9, 40));
        else send_binary_packet($urandom_range(1, 8));
      end else if (pick < 8) begin
        send_text_packet();
      end else begin
        repeat ($urandom_range(1, 3)) send_item(avoid_prefix(8'($urandom_range(0, 255))));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] directed_bytes[$];
    logic [7:0] prefixes[6];
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= 8'h00;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // prefix at reset value 0x00
    directed_bytes = '{
      // zero length binary packet
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      // two payload bytes at the extremes
      8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00,
      // text opening with CR; CR LF CR broken by a plain byte releases all three
      8'h0D, 8'h0A, 8'h0D, 8'h41,
      // CR on a held CR, then CR breaking CR LF CR, then the terminator
      8'h0D, 8'h0D, 8'h0A, 8'h0D, 8'h0D, 8'h0A, 8'h0D, 8'h0A
    };
    foreach (directed_bytes[i]) send_item(directed_bytes[i]);

    prefixes = '{8'hFF, 8'h0D, 8'h00, 8'($urandom_range(0, 255)), 8'h0A,
                 8'($urandom_range(0, 255))};
    foreach (prefixes[p]) begin
      wait_drained();
      write_prefix(prefixes[p]);
      rx_style = p % 4;
      if (p == 2) long_hold_req = 1'b1;
      run_random(54);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
